### rtl/ljpf_pkg.sv
// Shared types and constants of the Lennard-Jones pair force block.
// No dependencies; used by every other file of the block.
`default_nettype none

package ljpf_pkg;

   // Default count of particle species (table is species x species)
   localparam int MAX_SPECIES_DEF = 4;

   // Item opcodes
   localparam logic [2:0] OP_EVAL      = 3'd0;
   localparam logic [2:0] OP_WR_EPS    = 3'd1;
   localparam logic [2:0] OP_WR_SIGMA  = 3'd2;
   localparam logic [2:0] OP_WR_SHIFT  = 3'd3;
   localparam logic [2:0] OP_WR_CUTOFF = 3'd4;
   localparam logic [2:0] OP_CLR_SUM   = 3'd5;

   // Configuration register indexes
   localparam logic CSR_CHARGE_MODE   = 1'b0;
   localparam logic CSR_GLOBAL_CUTOFF = 1'b1;

   // Right-shift codes of the shared multiplier
   localparam logic [1:0] SH16 = 2'd0;
   localparam logic [1:0] SH24 = 2'd1;
   localparam logic [1:0] SH32 = 2'd2;

   // Quotient width of floor(2^56 / r)
   localparam int RECIP_BITS = 57;

   // Request to the shared multiplier
   typedef struct packed {
      logic       start;
      logic       neg;
      logic [1:0] sh;
   } mul_req_type;

endpackage

`default_nettype wire

### rtl/ljpf_mul.sv
// Shared 64x64 multiplier: four 32x32 partial products over cycles, then
// right shift, saturation and sign. Depends on ljpf_pkg.
`default_nettype none

module ljpf_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ljpf_pkg::mul_req_type mul_req,
   input  wire logic [63:0]          op_a,
   input  wire logic [63:0]          op_b,
   output logic [63:0]               res_u,
   output logic signed [63:0]        res_s,
   output logic                      done
);

   logic [63:0]        a_ff, a_in, b_ff, b_in;
   logic               neg_ff, neg_in;
   logic [1:0]         sh_ff, sh_in;
   logic [127:0]       acc_ff, acc_in;
   logic [63:0]        pp_ff, pp_in;
   logic [1:0]         pos_ff, pos_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [63:0]        ru_ff, ru_in;
   logic signed [63:0] rs_ff, rs_in;

   logic [31:0]  a_sel, b_sel;
   logic [127:0] pp_ext;
   logic [63:0]  u_val;
   logic         ovf;

   // Pick the halves for this step
   assign a_sel = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_sel = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   // Align the registered partial product
   always_comb begin
      case (pos_ff)
         2'd0:    pp_ext = {64'b0, pp_ff};
         2'd1:    pp_ext = {32'b0, pp_ff, 32'b0};
         default: pp_ext = {pp_ff, 64'b0};
      endcase
   end

   // Shift and saturate the full product
   always_comb begin
      case (sh_ff)
         ljpf_pkg::SH16: begin
            ovf   = |acc_ff[127:80];
            u_val = acc_ff[79:16];
         end
         ljpf_pkg::SH24: begin
            ovf   = |acc_ff[127:88];
            u_val = acc_ff[87:24];
         end
         default: begin
            ovf   = |acc_ff[127:96];
            u_val = acc_ff[95:32];
         end
      endcase
      if (ovf) begin
         u_val = {64{1'b1}};
      end
   end

   // Sequence the partial products
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      sh_in     = sh_ff;
      acc_in    = acc_ff;
      pp_in     = pp_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      ru_in     = ru_ff;
      rs_in     = rs_ff;
      if (mul_req.start) begin
         a_in      = op_a;
         b_in      = op_b;
         neg_in    = mul_req.neg;
         sh_in     = mul_req.sh;
         acc_in    = '0;
         cnt_in    = 3'd0;
         active_in = 1'b1;
      end else if (active_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff != 3'd0 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + pp_ext;
         end
         if (cnt_ff <= 3'd3) begin
            pp_in  = a_sel * b_sel;
            pos_in = (cnt_ff == 3'd0) ? 2'd0 : (cnt_ff == 3'd3) ? 2'd2 : 2'd1;
         end
         if (cnt_ff == 3'd5) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            ru_in     = u_val;
            if (neg_ff) begin
               rs_in = u_val[63] ? {1'b1, 63'b0} : -$signed(u_val);
            end else begin
               rs_in = u_val[63] ? {1'b0, {63{1'b1}}} : $signed(u_val);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= 3'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      pos_ff <= pos_in;
      ru_ff  <= ru_in;
      rs_ff  <= rs_in;
   end

   assign res_u = ru_ff;
   assign res_s = rs_ff;
   assign done  = done_ff;

endmodule

`default_nettype wire

### rtl/ljpf_div.sv
// Bit-serial restoring divider for floor(2^56 / r), one quotient bit a cycle.
// Depends on ljpf_pkg.
`default_nettype none

module ljpf_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [31:0]                       divisor,
   output logic [ljpf_pkg::RECIP_BITS-1:0]        quot,
   output logic                                   done
);

   localparam int QB = ljpf_pkg::RECIP_BITS;
   localparam int CW = $clog2(QB);

   logic [31:0]   d_ff, d_in;
   logic [31:0]   rem_ff, rem_in;
   logic [QB-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [32:0]   trial;
   logic          top_bit;

   // Dividend is a single one at the top quotient position
   assign top_bit = (cnt_ff == CW'(QB - 1));
   assign trial   = {rem_ff, top_bit};

   // Produce one quotient bit
   always_comb begin
      d_in      = d_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         d_in      = divisor;
         rem_in    = '0;
         cnt_in    = CW'(QB - 1);
         active_in = 1'b1;
      end else if (active_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = 32'(trial - {1'b0, d_ff});
            q_in   = {q_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[QB-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      d_ff   <= d_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

### rtl/lennard_jones_pair_force.sv
// Top level of the Lennard-Jones 12-6 pair force block: coefficient tables,
// sequencer and datapath registers. Depends on ljpf_pkg, ljpf_mul, ljpf_div.
//
//   channel  | direction | handshake            | carries
//   req_     | in        | req_valid/req_stall  | opcode, species, r, disp, charges, coef
//   rsp_     | out       | rsp_valid/rsp_stall  | energy, forces, within_cutoff, sum
//   csr_     | in        | csr_valid/csr_ready  | register index, data
//
// An evaluate item inside the cutoff holds the block from acceptance to the result:
// one table check, the bit-serial reciprocal of r, 12 passes (15 in charge mode)
// through the one shared multiplier, four register steps and the result. A write,
// clear or spare item goes straight to the result, an evaluate outside the cutoff
// after the table check; rsp_stall lengthens each. req_stall is high from acceptance
// until the result is taken; rsp_stall holds the result. Synchronous reset clears
// the sequencer, the energy sum, within_cutoff and the configuration registers;
// coefficient tables are undefined until written.
`default_nettype none

module lennard_jones_pair_force #(
   parameter int MaxSpecies = ljpf_pkg::MAX_SPECIES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [1:0]         req_species_i,
   input  wire logic [1:0]         req_species_j,
   input  wire logic [31:0]        req_distance,
   input  wire logic signed [31:0] req_disp_x,
   input  wire logic signed [31:0] req_disp_y,
   input  wire logic signed [31:0] req_disp_z,
   input  wire logic signed [31:0] req_charge_i,
   input  wire logic signed [31:0] req_charge_j,
   input  wire logic signed [31:0] req_coef_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [47:0]      rsp_pair_energy,
   output logic signed [47:0]      rsp_force_x,
   output logic signed [47:0]      rsp_force_y,
   output logic signed [47:0]      rsp_force_z,
   output logic                    rsp_within_cutoff,
   output logic signed [63:0]      rsp_energy_total,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int TDepth = MaxSpecies * MaxSpecies;
   localparam int IW     = (TDepth > 1) ? $clog2(TDepth) : 1;

   // Sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_CHECK = 5'd1;
   localparam logic [4:0] ST_DIV   = 5'd2;
   localparam logic [4:0] ST_S     = 5'd3;
   localparam logic [4:0] ST_S2    = 5'd4;
   localparam logic [4:0] ST_S4    = 5'd5;
   localparam logic [4:0] ST_S6    = 5'd6;
   localparam logic [4:0] ST_S12   = 5'd7;
   localparam logic [4:0] ST_SCALE = 5'd8;
   localparam logic [4:0] ST_DIFF  = 5'd9;
   localparam logic [4:0] ST_EN    = 5'd10;
   localparam logic [4:0] ST_ADDSH = 5'd11;
   localparam logic [4:0] ST_K1    = 5'd12;
   localparam logic [4:0] ST_K2    = 5'd13;
   localparam logic [4:0] ST_K3    = 5'd14;
   localparam logic [4:0] ST_Q     = 5'd15;
   localparam logic [4:0] ST_EQ    = 5'd16;
   localparam logic [4:0] ST_KQ    = 5'd17;
   localparam logic [4:0] ST_FX    = 5'd18;
   localparam logic [4:0] ST_FY    = 5'd19;
   localparam logic [4:0] ST_FZ    = 5'd20;
   localparam logic [4:0] ST_FIN   = 5'd21;
   localparam logic [4:0] ST_OUT   = 5'd22;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sext32(input logic [31:0] v);
      sext32 = {{32{v[31]}}, v};
   endfunction

   function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sadd64 = s[64] ? S64_MIN : S64_MAX;
      end else begin
         sadd64 = s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] usub(input logic [63:0] a,
                                                input logic [63:0] b);
      logic [63:0] m;
      if (a >= b) begin
         m    = a - b;
         usub = m[63] ? S64_MAX : $signed(m);
      end else begin
         m    = b - a;
         usub = m[63] ? S64_MIN : -$signed(m);
      end
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v[63:47] == {17{1'b0}} || v[63:47] == {17{1'b1}}) begin
         sat48 = v[47:0];
      end else begin
         sat48 = v[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end
   endfunction

   function automatic logic [63:0] usat_scale(input logic [63:0] v, input logic twelve);
      logic [67:0] t;
      if (twelve) begin
         t = ({4'b0, v} << 3) + ({4'b0, v} << 2);
      end else begin
         t = ({4'b0, v} << 2) + ({4'b0, v} << 1);
      end
      usat_scale = (t[67:64] != 4'b0) ? {64{1'b1}} : t[63:0];
   endfunction

   // Coefficient tables
   logic [31:0] eps_tbl_ff    [TDepth];
   logic [31:0] sigma_tbl_ff  [TDepth];
   logic [31:0] shift_tbl_ff  [TDepth];
   logic [31:0] cutoff_tbl_ff [TDepth];

   logic [4:0]         state_ff, state_in;
   logic               issued_ff, issued_in;
   logic               charge_mode_ff, charge_mode_in;
   logic [31:0]        gcut_ff, gcut_in;
   logic [1:0]         si_ff, si_in, sj_ff, sj_in;
   logic [31:0]        r_ff, r_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [31:0] qi_ff, qi_in, qj_ff, qj_in;
   logic signed [63:0] eps4_ff, eps4_in;
   logic [63:0]        sig_ff, sig_in;
   logic signed [31:0] shift_ff, shift_in;
   logic [63:0]        inv_ff, inv_in;
   logic [63:0]        s_ff, s_in, s2_ff, s2_in, s4_ff, s4_in;
   logic [63:0]        s6_ff, s6_in, s12_ff, s12_in;
   logic [63:0]        sc12_ff, sc12_in, sc6_ff, sc6_in;
   logic signed [63:0] d_ff, d_in, g_ff, g_in;
   logic signed [63:0] en_ff, en_in, k_ff, k_in, qij_ff, qij_in;
   logic signed [47:0] fx_ff, fx_in, fy_ff, fy_in, fz_ff, fz_in;
   logic signed [47:0] e_ff, e_in;
   logic               within_ff, within_in;
   logic signed [63:0] sum_ff, sum_in;

   logic               req_accept;
   logic               wr_en;
   logic [IW-1:0]      wr_ix_a, wr_ix_b;
   logic               wr_sp_ok, rd_sp_ok;
   logic               in_cut;
   logic [31:0]        tbl_eps_ff, tbl_sigma_ff, tbl_shift_ff, tbl_cut_ff;

   ljpf_pkg::mul_req_type mul_req;
   logic [63:0]           mul_a, mul_b, mul_u;
   logic signed [63:0]    mul_s;
   logic                  mul_done;
   logic                  mul_state;
   logic                  div_start, div_done;
   logic [ljpf_pkg::RECIP_BITS-1:0] div_q;

   ljpf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .res_u   (mul_u),
      .res_s   (mul_s),
      .done    (mul_done)
   );

   ljpf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (r_ff),
      .quot    (div_q),
      .done    (div_done)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;

   // Table addressing
   assign wr_sp_ok = (int'(req_species_i) < MaxSpecies) && (int'(req_species_j) < MaxSpecies);
   assign rd_sp_ok = (int'(si_ff) < MaxSpecies) && (int'(sj_ff) < MaxSpecies);
   assign wr_ix_a  = IW'(int'(req_species_i) * MaxSpecies + int'(req_species_j));
   assign wr_ix_b  = IW'(int'(req_species_j) * MaxSpecies + int'(req_species_i));
   assign wr_en    = req_accept && wr_sp_ok &&
                     (req_opcode == ljpf_pkg::OP_WR_EPS ||
                      req_opcode == ljpf_pkg::OP_WR_SIGMA ||
                      req_opcode == ljpf_pkg::OP_WR_SHIFT ||
                      req_opcode == ljpf_pkg::OP_WR_CUTOFF);

   // Cutoff test: global unsigned in charge mode, signed table entry otherwise
   assign in_cut = charge_mode_ff ? (r_ff < gcut_ff)
                                  : (!tbl_cut_ff[31] && r_ff < tbl_cut_ff);

   // Read the entries of an accepted pair; write both symmetric entries
   always_ff @(posedge clock) begin
      if (req_accept) begin
         tbl_eps_ff   <= eps_tbl_ff[wr_ix_a];
         tbl_sigma_ff <= sigma_tbl_ff[wr_ix_a];
         tbl_shift_ff <= shift_tbl_ff[wr_ix_a];
         tbl_cut_ff   <= cutoff_tbl_ff[wr_ix_a];
      end
      if (wr_en) begin
         case (req_opcode)
            ljpf_pkg::OP_WR_EPS: begin
               eps_tbl_ff[wr_ix_a] <= req_coef_value;
               if (wr_ix_b != wr_ix_a) begin
                  eps_tbl_ff[wr_ix_b] <= req_coef_value;
               end
            end
            ljpf_pkg::OP_WR_SIGMA: begin
               sigma_tbl_ff[wr_ix_a] <= req_coef_value;
               if (wr_ix_b != wr_ix_a) begin
                  sigma_tbl_ff[wr_ix_b] <= req_coef_value;
               end
            end
            ljpf_pkg::OP_WR_SHIFT: begin
               shift_tbl_ff[wr_ix_a] <= req_coef_value;
               if (wr_ix_b != wr_ix_a) begin
                  shift_tbl_ff[wr_ix_b] <= req_coef_value;
               end
            end
            default: begin
               cutoff_tbl_ff[wr_ix_a] <= req_coef_value;
               if (wr_ix_b != wr_ix_a) begin
                  cutoff_tbl_ff[wr_ix_b] <= req_coef_value;
               end
            end
         endcase
      end
   end

   // Route operands to the shared multiplier
   always_comb begin
      mul_state = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      mul_req   = '{start: 1'b0, neg: 1'b0, sh: ljpf_pkg::SH32};
      case (state_ff)
         ST_S: begin
            mul_a      = sig_ff;
            mul_b      = inv_ff;
            mul_req.sh = ljpf_pkg::SH24;
         end
         ST_S2: begin
            mul_a = s_ff;
            mul_b = s_ff;
         end
         ST_S4: begin
            mul_a = s2_ff;
            mul_b = s2_ff;
         end
         ST_S6: begin
            mul_a = s4_ff;
            mul_b = s2_ff;
         end
         ST_S12: begin
            mul_a = s6_ff;
            mul_b = s6_ff;
         end
         ST_EN: begin
            mul_a       = mag64(d_ff);
            mul_b       = mag64(eps4_ff);
            mul_req.neg = d_ff[63] ^ eps4_ff[63];
            mul_req.sh  = ljpf_pkg::SH24;
         end
         ST_K1: begin
            mul_a       = mag64(g_ff);
            mul_b       = mag64(eps4_ff);
            mul_req.neg = g_ff[63] ^ eps4_ff[63];
            mul_req.sh  = ljpf_pkg::SH24;
         end
         ST_K2, ST_K3: begin
            mul_a       = mag64(k_ff);
            mul_b       = inv_ff;
            mul_req.neg = k_ff[63];
         end
         ST_Q: begin
            mul_a       = mag64(sext32(qi_ff));
            mul_b       = mag64(sext32(qj_ff));
            mul_req.neg = qi_ff[31] ^ qj_ff[31];
            mul_req.sh  = ljpf_pkg::SH16;
         end
         ST_EQ: begin
            mul_a       = mag64(en_ff);
            mul_b       = mag64(qij_ff);
            mul_req.neg = en_ff[63] ^ qij_ff[63];
         end
         ST_KQ: begin
            mul_a       = mag64(k_ff);
            mul_b       = mag64(qij_ff);
            mul_req.neg = k_ff[63] ^ qij_ff[63];
         end
         ST_FX: begin
            mul_a       = mag64(k_ff);
            mul_b       = mag64(sext32(dx_ff));
            mul_req.neg = k_ff[63] ^ dx_ff[31];
            mul_req.sh  = ljpf_pkg::SH24;
         end
         ST_FY: begin
            mul_a       = mag64(k_ff);
            mul_b       = mag64(sext32(dy_ff));
            mul_req.neg = k_ff[63] ^ dy_ff[31];
            mul_req.sh  = ljpf_pkg::SH24;
         end
         ST_FZ: begin
            mul_a       = mag64(k_ff);
            mul_b       = mag64(sext32(dz_ff));
            mul_req.neg = k_ff[63] ^ dz_ff[31];
            mul_req.sh  = ljpf_pkg::SH24;
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
      mul_req.start = mul_state && !issued_ff;
   end

   assign div_start = (state_ff == ST_DIV) && !issued_ff;

   // Sequencer and datapath registers
   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      charge_mode_in = charge_mode_ff;
      gcut_in        = gcut_ff;
      si_in    = si_ff;
      sj_in    = sj_ff;
      r_in     = r_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      qi_in    = qi_ff;
      qj_in    = qj_ff;
      eps4_in  = eps4_ff;
      sig_in   = sig_ff;
      shift_in = shift_ff;
      inv_in   = inv_ff;
      s_in     = s_ff;
      s2_in    = s2_ff;
      s4_in    = s4_ff;
      s6_in    = s6_ff;
      s12_in   = s12_ff;
      sc12_in  = sc12_ff;
      sc6_in   = sc6_ff;
      d_in     = d_ff;
      g_in     = g_ff;
      en_in    = en_ff;
      k_in     = k_ff;
      qij_in   = qij_ff;
      fx_in    = fx_ff;
      fy_in    = fy_ff;
      fz_in    = fz_ff;
      e_in     = e_ff;
      within_in = within_ff;
      sum_in   = sum_ff;

      // Take configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ljpf_pkg::CSR_CHARGE_MODE: charge_mode_in = csr_data[0];
            default:                   gcut_in        = csr_data;
         endcase
      end

      // Hold pending multiplier or divider launch
      if ((mul_state || state_ff == ST_DIV) && !issued_ff) begin
         issued_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               si_in     = req_species_i;
               sj_in     = req_species_j;
               r_in      = req_distance;
               dx_in     = req_disp_x;
               dy_in     = req_disp_y;
               dz_in     = req_disp_z;
               qi_in     = req_charge_i;
               qj_in     = req_charge_j;
               e_in      = '0;
               fx_in     = '0;
               fy_in     = '0;
               fz_in     = '0;
               within_in = 1'b0;
               state_in  = ST_OUT;
               case (req_opcode)
                  ljpf_pkg::OP_EVAL:    state_in = ST_CHECK;
                  ljpf_pkg::OP_CLR_SUM: sum_in   = '0;
                  default:              state_in = ST_OUT;
               endcase
            end
         end
         ST_CHECK: begin
            if (rd_sp_ok && r_ff != 32'd0 && in_cut) begin
               eps4_in  = {{30{tbl_eps_ff[31]}}, tbl_eps_ff, 2'b00};
               sig_in   = {32'b0, tbl_sigma_ff[31] ? 32'(-tbl_sigma_ff) : tbl_sigma_ff};
               shift_in = tbl_shift_ff;
               state_in = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (issued_ff && div_done) begin
               inv_in    = {{(64 - ljpf_pkg::RECIP_BITS){1'b0}}, div_q};
               issued_in = 1'b0;
               state_in  = ST_S;
            end
         end
         ST_SCALE: begin
            sc12_in  = usat_scale(s12_ff, 1'b1);
            sc6_in   = usat_scale(s6_ff, 1'b0);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in     = usub(s12_ff, s6_ff);
            g_in     = usub(sc12_ff, sc6_ff);
            state_in = ST_EN;
         end
         ST_ADDSH: begin
            en_in    = sadd64(en_ff, {{24{shift_ff[31]}}, shift_ff, 8'b0});
            state_in = ST_K1;
         end
         ST_FIN: begin
            e_in      = sat48(en_ff);
            sum_in    = sadd64(sum_ff, {{16{e_in[47]}}, e_in});
            within_in = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
         end
      endcase

      // Capture the multiplier result and advance
      if (mul_state && issued_ff && mul_done) begin
         issued_in = 1'b0;
         case (state_ff)
            ST_S: begin
               s_in     = mul_u;
               state_in = ST_S2;
            end
            ST_S2: begin
               s2_in    = mul_u;
               state_in = ST_S4;
            end
            ST_S4: begin
               s4_in    = mul_u;
               state_in = ST_S6;
            end
            ST_S6: begin
               s6_in    = mul_u;
               state_in = ST_S12;
            end
            ST_S12: begin
               s12_in   = mul_u;
               state_in = ST_SCALE;
            end
            ST_EN: begin
               en_in    = mul_s;
               state_in = ST_ADDSH;
            end
            ST_K1: begin
               k_in     = mul_s;
               state_in = ST_K2;
            end
            ST_K2: begin
               k_in     = mul_s;
               state_in = ST_K3;
            end
            ST_K3: begin
               k_in     = mul_s;
               state_in = charge_mode_ff ? ST_Q : ST_FX;
            end
            ST_Q: begin
               qij_in   = mul_s;
               state_in = ST_EQ;
            end
            ST_EQ: begin
               en_in    = mul_s;
               state_in = ST_KQ;
            end
            ST_KQ: begin
               k_in     = mul_s;
               state_in = ST_FX;
            end
            ST_FX: begin
               fx_in    = sat48(mul_s);
               state_in = ST_FY;
            end
            ST_FY: begin
               fy_in    = sat48(mul_s);
               state_in = ST_FZ;
            end
            default: begin
               fz_in    = sat48(mul_s);
               state_in = ST_FIN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issued_ff      <= 1'b0;
         charge_mode_ff <= 1'b0;
         gcut_ff        <= '0;
         sum_ff         <= '0;
         within_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issued_ff      <= issued_in;
         charge_mode_ff <= charge_mode_in;
         gcut_ff        <= gcut_in;
         sum_ff         <= sum_in;
         within_ff      <= within_in;
      end
      si_ff    <= si_in;
      sj_ff    <= sj_in;
      r_ff     <= r_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      qi_ff    <= qi_in;
      qj_ff    <= qj_in;
      eps4_ff  <= eps4_in;
      sig_ff   <= sig_in;
      shift_ff <= shift_in;
      inv_ff   <= inv_in;
      s_ff     <= s_in;
      s2_ff    <= s2_in;
      s4_ff    <= s4_in;
      s6_ff    <= s6_in;
      s12_ff   <= s12_in;
      sc12_ff  <= sc12_in;
      sc6_ff   <= sc6_in;
      d_ff     <= d_in;
      g_ff     <= g_in;
      en_ff    <= en_in;
      k_ff     <= k_in;
      qij_ff   <= qij_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      fz_ff    <= fz_in;
      e_ff     <= e_in;
   end

   // Drive the result item
   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_pair_energy   = e_ff;
   assign rsp_force_x       = fx_ff;
   assign rsp_force_y       = fy_ff;
   assign rsp_force_z       = fz_ff;
   assign rsp_within_cutoff = within_ff;
   assign rsp_energy_total  = sum_ff;

endmodule

`default_nettype wire

### rtl/ljpf_checker.sv
// Port-level checks of the Lennard-Jones pair force block, bound to its top.
// Depends on ljpf_pkg and lennard_jones_pair_force.
`default_nettype none

module ljpf_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [2:0]         req_opcode,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [47:0] rsp_pair_energy,
   input wire logic signed [47:0] rsp_force_x,
   input wire logic signed [47:0] rsp_force_y,
   input wire logic signed [47:0] rsp_force_z,
   input wire logic               rsp_within_cutoff,
   input wire logic signed [63:0] rsp_energy_total
);

   // Stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pair_energy)
         && $stable(rsp_energy_total))
      else $error("stalled result changed");

   // Block goes busy after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after accept");

   // No new item while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open with result pending");

   // Out-of-cutoff result carries zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_within_cutoff |-> rsp_pair_energy == 48'sd0
         && rsp_force_x == 48'sd0 && rsp_force_y == 48'sd0 && rsp_force_z == 48'sd0)
      else $error("nonzero result outside cutoff");

   // Clear item reports an empty sum
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == ljpf_pkg::OP_CLR_SUM
         |=> rsp_valid && rsp_energy_total == 64'sd0)
      else $error("sum not cleared");

endmodule

bind lennard_jones_pair_force ljpf_checker u_ljpf_checker (.*);

`default_nettype wire

### tb/tb.sv
// Testbench of lennard_jones_pair_force: drives pair items, checks each result
// against an in-bench fixed-point force predictor. Depends on ljpf_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam int unsigned ONE_Q24 = 32'h0100_0000;
   localparam longint CYCLE_LIMIT = 3_000_000;
   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      logic [2:0]  opcode;
      logic [1:0]  sp_i;
      logic [1:0]  sp_j;
      logic [31:0] r_dist;
      logic [31:0] dx, dy, dz;
      logic [31:0] qi, qj;
      logic [31:0] coef;
   } pair_item_type;

   typedef struct {
      logic [47:0] energy;
      logic [47:0] fx, fy, fz;
      logic        in_cut;
      logic [63:0] total;
   } force_result_type;

   typedef struct {
      pair_item_type    it;
      bit               typed;
      force_result_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid, req_stall;
   logic [2:0] req_opcode;
   logic [1:0] req_species_i, req_species_j;
   logic [31:0] req_distance;
   logic signed [31:0] req_disp_x, req_disp_y, req_disp_z;
   logic signed [31:0] req_charge_i, req_charge_j, req_coef_value;
   logic rsp_valid, rsp_stall;
   logic signed [47:0] rsp_pair_energy, rsp_force_x, rsp_force_y, rsp_force_z;
   logic rsp_within_cutoff;
   logic signed [63:0] rsp_energy_total;
   logic csr_valid, csr_ready, csr_index;
   logic [31:0] csr_data;

   lennard_jones_pair_force uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [31:0] eps_tab [16];
   logic [31:0] sigma_tab [16];
   logic [31:0] shift_tab [16];
   logic [31:0] cutoff_tab [16];
   longint      sum_model;
   logic        mode_model;
   logic [31:0] gcut_model;

   force_result_type pending_results [$];
   bit failed = 1'b0;
   bit steady = 1'b0;
   longint cycles = 0;

   // ---------------- fixed-point helpers ----------------
   function automatic logic [63:0] umul_sh(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> sh;
      return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
   endfunction

   function automatic longint from_mag(bit neg, logic [63:0] m);
      if (neg) return m[63] ? S64_MIN : -longint'(m);
      return m[63] ? S64_MAX : longint'(m);
   endfunction

   function automatic logic [63:0] umag(longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
   endfunction

   function automatic longint smul(longint a, longint b, int sh);
      return from_mag((a < 0) != (b < 0), umul_sh(umag(a), umag(b), sh));
   endfunction

   function automatic longint sadd(longint a, longint b);
      logic [64:0] w;
      w = {a[63], a} + {b[63], b};
      if (w[64] != w[63]) return w[64] ? S64_MIN : S64_MAX;
      return longint'(w[63:0]);
   endfunction

   function automatic longint udiff(logic [63:0] a, logic [63:0] b);
      return (a >= b) ? from_mag(1'b0, a - b) : from_mag(1'b1, b - a);
   endfunction

   function automatic logic [47:0] sat48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return 48'h8000_0000_0000;
      return v[47:0];
   endfunction

   function automatic longint sx32(logic [31:0] v);
      return longint'($signed(v));
   endfunction

   // Work out the result of one accepted item and advance the predictor state.
   function automatic force_result_type predict_pair_force(pair_item_type it);
      force_result_type res;
      int ix, ixt;
      bit in_range;
      longint eps4, shv, d, g, en, k, qij;
      logic [63:0] sig, inv_r, s, s2, s4, s6, s12;
      res = '{default: '0};
      ix = it.sp_i * 4 + it.sp_j;
      ixt = it.sp_j * 4 + it.sp_i;
      case (it.opcode)
         ljpf_pkg::OP_WR_EPS: begin
            eps_tab[ix] = it.coef; eps_tab[ixt] = it.coef;
         end
         ljpf_pkg::OP_WR_SIGMA: begin
            sigma_tab[ix] = it.coef; sigma_tab[ixt] = it.coef;
         end
         ljpf_pkg::OP_WR_SHIFT: begin
            shift_tab[ix] = it.coef; shift_tab[ixt] = it.coef;
         end
         ljpf_pkg::OP_WR_CUTOFF: begin
            cutoff_tab[ix] = it.coef; cutoff_tab[ixt] = it.coef;
         end
         ljpf_pkg::OP_CLR_SUM: sum_model = 0;
         ljpf_pkg::OP_EVAL: if (it.r_dist != 0) begin
            in_range = mode_model ? (it.r_dist < gcut_model)
                                  : (longint'(it.r_dist) < sx32(cutoff_tab[ix]));
            if (in_range) begin
               eps4 = 4 * sx32(eps_tab[ix]);
               sig = umag(sx32(sigma_tab[ix]));
               shv = sx32(shift_tab[ix]);
               inv_r = (64'd1 << 56) / 64'(it.r_dist);
               s = umul_sh(sig, inv_r, 24);
               s2 = umul_sh(s, s, 32);
               s4 = umul_sh(s2, s2, 32);
               s6 = umul_sh(s4, s2, 32);
               s12 = umul_sh(s6, s6, 32);
               d = udiff(s12, s6);
               g = udiff(umul_sh(s12, 64'd12, 0), umul_sh(s6, 64'd6, 0));
               en = sadd(smul(d, eps4, 24), shv * 256);
               k = smul(g, eps4, 24);
               k = smul(k, longint'(inv_r), 32);
               k = smul(k, longint'(inv_r), 32);
               if (mode_model) begin
                  qij = smul(sx32(it.qi), sx32(it.qj), 16);
                  en = smul(en, qij, 32);
                  k = smul(k, qij, 32);
               end
               res.energy = sat48(en);
               res.fx = sat48(smul(k, sx32(it.dx), 24));
               res.fy = sat48(smul(k, sx32(it.dy), 24));
               res.fz = sat48(smul(k, sx32(it.dz), 24));
               res.in_cut = 1'b1;
               sum_model = sadd(sum_model, longint'($signed(res.energy)));
            end
         end
         default: ;
      endcase
      res.total = sum_model;
      return res;
   endfunction

   // ---------------- driving ----------------
   // Send one item after a random gap, or none when steady; push the expectation when it is accepted.
   task automatic send_item(pair_item_type it, bit typed, force_result_type typed_res);
      int gap;
      force_result_type res;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_species_i <= it.sp_i;
      req_species_j <= it.sp_j;
      req_distance <= it.r_dist;
      req_disp_x <= it.dx;
      req_disp_y <= it.dy;
      req_disp_z <= it.dz;
      req_charge_i <= it.qi;
      req_charge_j <= it.qj;
      req_coef_value <= it.coef;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = predict_pair_force(it);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   // Drain all results, then write one configuration register.
   task automatic write_csr(logic idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == ljpf_pkg::CSR_CHARGE_MODE) mode_model = value[0];
      else gcut_model = value;
   endtask

   function automatic pair_item_type mk(logic [2:0] op, logic [1:0] i, logic [1:0] j,
                                        logic [31:0] r, logic [31:0] c);
      pair_item_type it;
      it = '{opcode: op, sp_i: i, sp_j: j, r_dist: r, dx: ONE_Q24, dy: -ONE_Q24,
             dz: ONE_Q24 / 2, qi: ONE_Q24, qj: -ONE_Q24, coef: c};
      return it;
   endfunction

   function automatic logic [31:0] rand_coef(logic [2:0] op);
      if ($urandom_range(0, 9) == 0) return $urandom;
      case (op)
         ljpf_pkg::OP_WR_EPS:
            return $urandom_range(0, 2 * ONE_Q24) * ($urandom_range(0, 7) ? 1 : -1);
         ljpf_pkg::OP_WR_SIGMA:  return $urandom_range(ONE_Q24 / 2, 3 * ONE_Q24 / 2);
         ljpf_pkg::OP_WR_SHIFT:  return $urandom_range(0, ONE_Q24) - ONE_Q24 / 2;
         default:                return $urandom_range(ONE_Q24, 4 * ONE_Q24);
      endcase
   endfunction

   function automatic pair_item_type rand_item();
      pair_item_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it.sp_i = 2'($urandom); it.sp_j = 2'($urandom);
      it.coef = $urandom;
      it.dx = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4 * ONE_Q24) - 2 * ONE_Q24;
      it.dy = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4 * ONE_Q24) - 2 * ONE_Q24;
      it.dz = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4 * ONE_Q24) - 2 * ONE_Q24;
      it.qi = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * ONE_Q24) - ONE_Q24;
      it.qj = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * ONE_Q24) - ONE_Q24;
      it.r_dist = $urandom_range(7 * ONE_Q24 / 10, 3 * ONE_Q24);
      it.opcode = ljpf_pkg::OP_EVAL;
      if (pick < 8) begin
         it.opcode = 3'($urandom_range(1, 4));
         it.coef = rand_coef(it.opcode);
      end else if (pick < 11) it.opcode = ljpf_pkg::OP_CLR_SUM;
      else if (pick < 13) it.opcode = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      else if (pick < 25) it.r_dist = $urandom;
      else if (pick < 27) it.r_dist = 32'd0;
      return it;
   endfunction

   // ---------------- result check ----------------
   int hold_cnt = 0;
   always @(posedge clock) begin
      force_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result with none expected", $time);
               failed = 1'b1;
            end else begin
               e = pending_results.pop_front();
               if (rsp_pair_energy !== e.energy) begin
                  $display("%0t: pair_energy exp %h got %h", $time, e.energy, rsp_pair_energy);
                  failed = 1'b1;
               end
               if (rsp_force_x !== e.fx) begin
                  $display("%0t: force_x exp %h got %h", $time, e.fx, rsp_force_x);
                  failed = 1'b1;
               end
               if (rsp_force_y !== e.fy) begin
                  $display("%0t: force_y exp %h got %h", $time, e.fy, rsp_force_y);
                  failed = 1'b1;
               end
               if (rsp_force_z !== e.fz) begin
                  $display("%0t: force_z exp %h got %h", $time, e.fz, rsp_force_z);
                  failed = 1'b1;
               end
               if (rsp_within_cutoff !== e.in_cut) begin
                  $display("%0t: within_cutoff exp %b got %b", $time, e.in_cut,
                           rsp_within_cutoff);
                  failed = 1'b1;
               end
               if (rsp_energy_total !== e.total) begin
                  $display("%0t: energy_total exp %h got %h", $time, e.total,
                           rsp_energy_total);
                  failed = 1'b1;
               end
            end
            hold_cnt = steady ? 0 : $urandom_range(0, 15);
         end
         // stall for the drawn count, then release
         rsp_stall <= (hold_cnt != 0);
         if (hold_cnt != 0) hold_cnt = hold_cnt - 1;
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   stim_row_type rows [$];
   force_result_type zero_res;
   logic [31:0] gcuts [6];

   initial begin
      pair_item_type it;
      zero_res = '{default: '0};
      req_valid <= 1'b0;
      req_opcode <= ljpf_pkg::OP_EVAL;
      req_species_i <= '0; req_species_j <= '0;
      req_distance <= '0;
      req_disp_x <= '0; req_disp_y <= '0; req_disp_z <= '0;
      req_charge_i <= '0; req_charge_j <= '0; req_coef_value <= '0;
      csr_valid <= 1'b0; csr_index <= ljpf_pkg::CSR_CHARGE_MODE; csr_data <= '0;
      foreach (eps_tab[n]) begin
         eps_tab[n] = '0; sigma_tab[n] = '0; shift_tab[n] = '0; cutoff_tab[n] = '0;
      end
      sum_model = 0; mode_model = 1'b0; gcut_model = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: zero distance, spare opcodes and clear touch no table entry
      rows.push_back('{mk(ljpf_pkg::OP_EVAL, 2'd0, 2'd0, 32'd0, 32'd0), 1'b1, zero_res});
      it = mk(OP_SPARE6, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      rows.push_back('{it, 1'b1, zero_res});
      rows.push_back('{mk(OP_SPARE7, 2'd1, 2'd2, ONE_Q24, 32'h8000_0000), 1'b1, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_CLR_SUM, 2'd0, 2'd0, ONE_Q24, 32'd0), 1'b1, zero_res});
      foreach (rows[n]) send_item(rows[n].it, rows[n].typed, rows[n].res);
      rows.delete();

      // fill every table entry before any lookup
      for (int i = 0; i < 4; i++)
         for (int j = i; j < 4; j++)
            for (int op = 1; op <= 4; op++)
               send_item(mk(3'(op), 2'(i), 2'(j), 32'd0, rand_coef(3'(op))), 1'b1, zero_res);

      // directed pairs: exact sigma, tiny and huge r, negative cutoff, extremes
      rows.push_back('{mk(ljpf_pkg::OP_WR_SIGMA, 2'd0, 2'd0, 0, ONE_Q24), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_WR_CUTOFF, 2'd0, 2'd0, 0, 3 * ONE_Q24), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_WR_EPS, 2'd0, 2'd0, 0, ONE_Q24), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_EVAL, 2'd0, 2'd0, ONE_Q24, 0), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_EVAL, 2'd0, 2'd0, 32'd1, 0), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_EVAL, 2'd0, 2'd0, 32'hFFFF_FFFF, 0), 1'b0, zero_res});
      it = mk(ljpf_pkg::OP_WR_CUTOFF, 2'd1, 2'd2, 0, 32'h8000_0000);
      rows.push_back('{it, 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_EVAL, 2'd2, 2'd1, 32'd1, 0), 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_WR_EPS, 2'd3, 2'd0, 0, 32'h8000_0000), 1'b0, zero_res});
      it = mk(ljpf_pkg::OP_WR_CUTOFF, 2'd3, 2'd0, 0, 32'h7FFF_FFFF);
      rows.push_back('{it, 1'b0, zero_res});
      it = mk(ljpf_pkg::OP_EVAL, 2'd0, 2'd3, ONE_Q24 + 5, 0);
      it.dx = 32'h8000_0000; it.dy = 32'h7FFF_FFFF; it.dz = 32'd0;
      rows.push_back('{it, 1'b0, zero_res});
      rows.push_back('{mk(ljpf_pkg::OP_CLR_SUM, 2'd2, 2'd1, 0, 0), 1'b1, zero_res});
      foreach (rows[n]) send_item(rows[n].it, rows[n].typed, rows[n].res);

      // random phases across register settings, extremes included
      gcuts = '{32'd0, 3 * ONE_Q24, 32'hFFFF_FFFF, 2 * ONE_Q24, 32'h8000_0000, 32'd1};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(ljpf_pkg::CSR_CHARGE_MODE, 32'(ph % 2));
         write_csr(ljpf_pkg::CSR_GLOBAL_CUTOFF, gcuts[ph]);
         steady = (ph == 2);
         repeat (200) send_item(rand_item(), 1'b0, zero_res);
      end
      steady = 1'b0;

      // drain and settle
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
